@@ rtl/core/swarq_pkg.sv @@
// shared types, constants and helpers of the stop-and-wait arq receiver
package swarq_pkg;

	localparam int PAYLOAD_BYTES_DEF = 509;
	localparam int CMD_DEPTH_DEF     = 4;
	localparam int RES_DEPTH_DEF     = 2;

	// widest payload count over the supported payload sizes (up to 1023)
	localparam int CNT_W = 10;
	localparam int MSG_W = 24;

	localparam logic [7:0] CODE_ACK  = 8'h01;
	localparam logic [7:0] CODE_NAK  = 8'h02;
	localparam logic [7:0] TYPE_LAST = 8'h08;
	localparam logic [7:0] SUM_GOOD  = 8'hFF;
	localparam logic [7:0] SEQ_NONE  = 8'hFF;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPLY   = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       datagram_end;
	} in_word_t;

	typedef struct packed {
		logic             result_kind;
		logic [7:0]       payload_byte;
		logic             reply_is_nak;
		logic [7:0]       reply_seq;
		logic [7:0]       reply_check;
		logic             accepted;
		logic             message_done;
		logic [MSG_W-1:0] message_length;
		logic             short_packet;
	} out_word_t;

	// classified word handed from the front to the back
	typedef struct packed {
		logic             is_reply;
		logic [7:0]       data;
		logic             sum_ok;
		logic             is_last;
		logic [7:0]       seq;
		logic [CNT_W-1:0] count;
		logic             short_pkt;
	} cmd_t;

	// one's-complement add with end-around carry
	function automatic logic [7:0] oc_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[7:0] + {7'd0, s[8]};
	endfunction

endpackage

@@ rtl/core/swarq_fifo.sv @@
// small register queue used between the stages and at the result side
module swarq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

@@ rtl/core/swarq_front.sv @@
// front stage: byte position tracking, checksum and header capture, classification
module swarq_front import swarq_pkg::*; #(
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  in_word_t word,
	output logic     cmd_valid,
	output cmd_t     cmd
);

	localparam int FULL_LEN = PAYLOAD_BYTES + 4;
	localparam int POS_W    = $clog2(FULL_LEN + 1);
	localparam int CMP_W    = (POS_W > 9) ? POS_W : 9;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       sum_q;
	logic [7:0]       type_q;
	logic [7:0]       seq_q;
	logic [7:0]       len_q;

	logic             first;
	logic             live;
	logic [7:0]       b;
	logic [7:0]       sum_d;
	logic [7:0]       type_d;
	logic [7:0]       seq_d;
	logic [7:0]       len_d;
	logic [7:0]       len_cap;
	logic [CMP_W-1:0] p_c;
	logic [CMP_W-1:0] lo;
	logic [CMP_W-1:0] hi;
	logic [CMP_W-1:0] hi_m;
	logic [CMP_W-1:0] n;
	logic             is_last;
	logic             in_win;

	assign b     = word.data_byte;
	assign first = (pos_q == '0);
	assign live  = (pos_q < POS_W'(FULL_LEN));
	assign p_c   = CMP_W'(pos_q);

	assign len_cap = (CNT_W'(b) < CNT_W'(PAYLOAD_BYTES)) ? b : 8'(PAYLOAD_BYTES);

	always_comb begin
		sum_d  = sum_q;
		type_d = type_q;
		seq_d  = seq_q;
		len_d  = len_q;
		if (live) begin
			if (first) begin
				type_d = '0;
				seq_d  = '0;
				len_d  = '0;
			end
			sum_d = oc_add(first ? 8'd0 : sum_q, b);
			if (pos_q == POS_W'(1)) begin
				type_d = b;
			end else if (pos_q == POS_W'(2)) begin
				seq_d = b;
			end else if (pos_q == POS_W'(3) && type_q == TYPE_LAST) begin
				len_d = len_cap;
			end
		end
	end

	assign is_last = (type_d == TYPE_LAST);
	assign lo      = is_last ? CMP_W'(4) : CMP_W'(3);
	assign hi      = is_last ? CMP_W'(len_d) + CMP_W'(4) : CMP_W'(PAYLOAD_BYTES + 3);
	assign in_win  = (p_c >= lo) && (p_c < hi);
	assign hi_m    = (p_c < hi) ? p_c : hi;
	assign n       = (hi_m > lo) ? hi_m - lo : '0;

	assign cmd_valid = take && (word.datagram_end || (live && in_win));

	always_comb begin
		cmd           = '0;
		cmd.is_reply  = word.datagram_end;
		cmd.data      = b;
		cmd.sum_ok    = (sum_d == SUM_GOOD);
		cmd.is_last   = is_last;
		cmd.seq       = seq_d;
		cmd.count     = CNT_W'(n);
		cmd.short_pkt = (p_c + CMP_W'(1)) < CMP_W'(FULL_LEN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			sum_q  <= '0;
			type_q <= '0;
			seq_q  <= '0;
			len_q  <= '0;
		end else if (take) begin
			sum_q  <= sum_d;
			type_q <= type_d;
			seq_q  <= seq_d;
			len_q  <= len_d;
			if (word.datagram_end) begin
				pos_q <= '0;
			end else if (live) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/swarq_back.sv @@
// back stage: payload pass-through, reply build, duplicate check, message length
module swarq_back import swarq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_take,
	input  logic      res_full,
	output logic      res_valid,
	output out_word_t res
);

	logic [7:0]       prev_q;
	logic [MSG_W-1:0] cnt_q;

	logic [7:0]       code;
	logic             acc;
	logic             done;
	logic [MSG_W:0]   sum_ext;
	logic [MSG_W-1:0] cnt_sat;
	logic [MSG_W-1:0] reported;

	assign cmd_take  = cmd_valid && !res_full;
	assign res_valid = cmd_take;

	assign code     = cmd.sum_ok ? CODE_ACK : CODE_NAK;
	assign acc      = cmd.sum_ok && (cmd.seq != prev_q);
	assign done     = acc && cmd.is_last;
	assign sum_ext  = {1'b0, cnt_q} + (MSG_W + 1)'(cmd.count);
	assign cnt_sat  = sum_ext[MSG_W] ? '1 : sum_ext[MSG_W-1:0];
	assign reported = acc ? cnt_sat : cnt_q;

	always_comb begin
		res = '0;
		if (cmd.is_reply) begin
			res.result_kind    = KIND_REPLY;
			res.reply_is_nak   = !cmd.sum_ok;
			res.reply_seq      = cmd.seq;
			res.reply_check    = ~oc_add(code, cmd.seq);
			res.accepted       = acc;
			res.message_done   = done;
			res.message_length = reported;
			res.short_packet   = cmd.short_pkt;
		end else begin
			res.result_kind  = KIND_PAYLOAD;
			res.payload_byte = cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= SEQ_NONE;
			cnt_q  <= '0;
		end else if (cmd_take && cmd.is_reply && acc) begin
			prev_q <= cmd.seq;
			cnt_q  <= done ? '0 : cnt_sat;
		end
	end

endmodule

@@ rtl/core/stop_wait_arq_receiver.sv @@
// top level of the stop-and-wait arq receiver
//
// Bytes of datagrams enter as words on the item queue port
// (push/full) and results leave on the result queue port (empty/pop).
// Each body byte in the payload window comes out as a tentative payload
// word; the byte marked datagram_end yields one reply word with ACK/NAK,
// echoed sequence, reply check byte, accept flag and message length.
// One byte is taken every cycle while full is low. On the way to the
// result port, the front classifies each payload or reply into the
// command queue, and the back stage moves it on into the result queue
// whenever the result queue has room.
// When the result side stops popping, the result queue and then the
// command queue fill; full rises once the command queue has no room and
// no word is lost. Reset clears the byte position, the checksum, both
// queues, the message length and sets the last seen sequence to 0xFF.
module stop_wait_arq_receiver import swarq_pkg::*; #(
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
	parameter int CMD_DEPTH     = CMD_DEPTH_DEF,
	parameter int RES_DEPTH     = RES_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_word_t  item,
	output logic      full,
	input  logic      pop,
	output out_word_t result,
	output logic      empty
);

	logic      take;
	logic      cmd_valid;
	cmd_t      cmd_in;
	cmd_t      cmd_out;
	logic      cmd_empty;
	logic      cmd_take;
	logic      res_full;
	logic      res_valid;
	out_word_t res_in;

	assign take = push && !full;

	swarq_front #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.word      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_in)
	);

	swarq_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_valid),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_take),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	swarq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_take  (cmd_take),
		.res_full  (res_full),
		.res_valid (res_valid),
		.res       (res_in)
	);

	swarq_fifo #(
		.WIDTH($bits(out_word_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

@@ bench/tb_top.sv @@
// self-checking bench of the stop-and-wait arq receiver: directed table, then random datagrams
module tb_top;
	import swarq_pkg::*;

	localparam int PAYLOAD    = PAYLOAD_BYTES_DEF;
	localparam int FULL_LEN   = PAYLOAD + 4;
	localparam int SMALL_BYTES = 800;
	localparam int HOLD_AT    = 200;
	localparam int HOLD_OFF   = 300;
	localparam int STALL_LIMIT = 3000;
	localparam logic [MSG_W-1:0] MSG_MAX = {MSG_W{1'b1}};

	typedef struct packed {
		in_word_t  w;
		logic      typed;
		out_word_t want;
	} row_t;

	localparam out_word_t NONE = '0;
	// first packet with sequence 0xff counts as a duplicate
	localparam out_word_t DUP_AT_RESET =
		'{KIND_REPLY, 8'h00, 1'b0, 8'hFF, 8'hFE, 1'b0, 1'b0, 24'd0, 1'b1};
	// lone zero byte: sum stays zero, so a nak
	localparam out_word_t NAK_ZERO =
		'{KIND_REPLY, 8'h00, 1'b1, 8'h00, 8'hFD, 1'b0, 1'b0, 24'd0, 1'b1};

	localparam row_t DIRECTED [22] = '{
		'{'{8'h00, 1'b0}, 1'b0, NONE},
		'{'{8'h00, 1'b0}, 1'b0, NONE},
		'{'{8'hFF, 1'b1}, 1'b1, DUP_AT_RESET},
		'{'{8'h00, 1'b1}, 1'b1, NAK_ZERO},
		'{'{8'h58, 1'b0}, 1'b0, NONE},
		'{'{8'h01, 1'b0}, 1'b0, NONE},
		'{'{8'h01, 1'b0}, 1'b0, NONE},
		'{'{8'h00, 1'b0}, 1'b0, NONE},
		'{'{8'hFF, 1'b0}, 1'b0, NONE},
		'{'{8'hA5, 1'b1}, 1'b0, NONE},
		'{'{8'h8D, 1'b0}, 1'b0, NONE},
		'{'{TYPE_LAST, 1'b0}, 1'b0, NONE},
		'{'{8'h02, 1'b0}, 1'b0, NONE},
		'{'{8'h02, 1'b0}, 1'b0, NONE},
		'{'{8'h11, 1'b0}, 1'b0, NONE},
		'{'{8'h22, 1'b0}, 1'b0, NONE},
		'{'{8'h33, 1'b1}, 1'b0, NONE},
		'{'{8'hF3, 1'b0}, 1'b0, NONE},
		'{'{TYPE_LAST, 1'b0}, 1'b0, NONE},
		'{'{8'h04, 1'b0}, 1'b0, NONE},
		'{'{8'hFF, 1'b0}, 1'b0, NONE},
		'{'{8'hFF, 1'b1}, 1'b0, NONE}
	};

	logic      clk;
	logic      arst_n;
	logic      push;
	in_word_t  item;
	logic      full;
	logic      pop;
	out_word_t result;
	logic      empty;

	row_t      offered = '0;
	row_t      wire_bytes[$];
	out_word_t pending_words[$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	logic [7:0] gen_seq = 8'h00;

	// receiver image
	logic [CNT_W:0]   at_byte;
	logic [7:0]       csum;
	logic [7:0]       pkt_type;
	logic [7:0]       pkt_seq;
	logic [8:0]       last_len;
	logic [7:0]       seen_seq;
	logic [MSG_W-1:0] msg_bytes;

	bit        has_word;
	out_word_t predicted;
	out_word_t oldest;

	assign item = offered.w;

	stop_wait_arq_receiver #(
		.PAYLOAD_BYTES(PAYLOAD)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.pop(pop),
		.result(result),
		.empty(empty)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] ones_add(input logic [7:0] a, input logic [7:0] b);
		int s;
		s = a + b;
		if (s > 255)
			s = s - 255;
		return s[7:0];
	endfunction

	task automatic receive_byte(input in_word_t w, output bit has, output out_word_t r);
		logic [CNT_W:0] p;
		logic [7:0] b;
		logic [7:0] code;
		bit live, good, keep, done;
		int unsigned lo, hi, q, n, total;
		p = at_byte;
		b = w.data_byte;
		live = p < FULL_LEN;
		r = '0;
		has = 1'b0;
		if (live) begin
			if (p == 0) begin
				pkt_type = 8'h00;
				pkt_seq = 8'h00;
				last_len = '0;
				csum = 8'h00;
			end
			csum = ones_add(csum, b);
			if (p == 1)
				pkt_type = b;
			else if (p == 2)
				pkt_seq = b;
			else if (p == 3 && pkt_type == TYPE_LAST)
				last_len = (b < PAYLOAD) ? 9'(b) : 9'(PAYLOAD);
			at_byte = p + 1'b1;
		end
		lo = (pkt_type == TYPE_LAST) ? 4 : 3;
		hi = (pkt_type == TYPE_LAST) ? last_len + 4 : PAYLOAD + 3;
		if (!w.datagram_end) begin
			if (live && p >= lo && p < hi) begin
				has = 1'b1;
				r.result_kind = KIND_PAYLOAD;
				r.payload_byte = b;
			end
		end else begin
			good = csum == SUM_GOOD;
			code = good ? CODE_ACK : CODE_NAK;
			keep = good && pkt_seq != seen_seq;
			done = 1'b0;
			if (keep) begin
				q = (p < FULL_LEN) ? p : FULL_LEN;
				if (q < hi)
					hi = q;
				n = (hi > lo) ? hi - lo : 0;
				seen_seq = pkt_seq;
				total = msg_bytes + n;
				msg_bytes = (total > MSG_MAX) ? MSG_MAX : MSG_W'(total);
				done = pkt_type == TYPE_LAST;
			end
			has = 1'b1;
			r.result_kind = KIND_REPLY;
			r.reply_is_nak = !good;
			r.reply_seq = pkt_seq;
			r.reply_check = ~ones_add(code, pkt_seq);
			r.accepted = keep;
			r.message_done = done;
			r.message_length = msg_bytes;
			r.short_packet = (p + 1) < FULL_LEN;
			if (done)
				msg_bytes = '0;
			at_byte = '0;
			csum = 8'h00;
		end
	endtask

	// one datagram of len bytes, check byte fixed up unless corrupted
	task automatic build_datagram(input int len, input bit plain, input bit corrupt);
		logic [7:0] bytes[$];
		logic [7:0] sum;
		int summed;
		int k;
		row_t r;
		bytes.push_back(8'h00);
		for (k = 1; k < len; k++)
			bytes.push_back(8'($urandom_range(0, 255)));
		if (len > 1) begin
			case ($urandom_range(0, 9))
				0, 1, 2: bytes[1] = TYPE_LAST;
				3: bytes[1] = 8'h00;
				4: bytes[1] = 8'hFF;
				default: ;
			endcase
			if (plain)
				bytes[1] = 8'h00;
		end
		if (len > 2) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: bytes[2] = gen_seq + 8'd1;
				4, 5: bytes[2] = gen_seq;
				6: bytes[2] = SEQ_NONE;
				default: ;
			endcase
		end
		if (len > 3 && bytes[1] == TYPE_LAST && $urandom_range(0, 1) == 1)
			bytes[3] = 8'($urandom_range(0, len));
		summed = (len < FULL_LEN) ? len : FULL_LEN;
		sum = 8'h00;
		for (k = 1; k < summed; k++)
			sum = ones_add(sum, bytes[k]);
		bytes[0] = ~sum;
		if (corrupt) begin
			k = $urandom_range(0, summed - 1);
			bytes[k] = bytes[k] ^ 8'($urandom_range(1, 255));
		end else if (len > 2) begin
			gen_seq = bytes[2];
		end
		for (k = 0; k < len; k++) begin
			r = '0;
			r.w.data_byte = bytes[k];
			r.w.datagram_end = (k == len - 1);
			wire_bytes.push_back(r);
		end
	endtask

	task automatic compare_field(input string name, input longint unsigned exp_v,
		input longint unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			receive_byte(offered.w, has_word, predicted);
			if (has_word)
				pending_words.push_back(offered.typed ? offered.want : predicted);
		end
		if (arst_n && pop && !empty) begin
			if (pending_words.size() == 0) begin
				$error("result word with nothing pending: %h", result);
				mismatches++;
			end else begin
				oldest = pending_words.pop_front();
				compare_field("result_kind", oldest.result_kind, result.result_kind);
				compare_field("payload_byte", oldest.payload_byte, result.payload_byte);
				compare_field("reply_is_nak", oldest.reply_is_nak, result.reply_is_nak);
				compare_field("reply_seq", oldest.reply_seq, result.reply_seq);
				compare_field("reply_check", oldest.reply_check, result.reply_check);
				compare_field("accepted", oldest.accepted, result.accepted);
				compare_field("message_done", oldest.message_done, result.message_done);
				compare_field("message_length", oldest.message_length, result.message_length);
				compare_field("short_packet", oldest.short_packet, result.short_packet);
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side
	initial begin
		int gap;
		int taken;
		bit steady;
		taken = 0;
		steady = 1'b0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			gap = steady ? 0 : $urandom_range(0, 14);
			if (taken == HOLD_AT)
				gap = HOLD_OFF;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			taken++;
		end
	end

	initial begin
		int gap;
		int i;
		int len;
		bit steady;
		steady = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		at_byte = '0;
		csum = 8'h00;
		pkt_type = 8'h00;
		pkt_seq = 8'h00;
		last_len = '0;
		seen_seq = SEQ_NONE;
		msg_bytes = '0;

		foreach (DIRECTED[k])
			wire_bytes.push_back(DIRECTED[k]);
		// overlong ordinary packet: full payload, trailing bytes ignored
		build_datagram(FULL_LEN + 3, 1'b1, 1'b0);
		while (wire_bytes.size() < SMALL_BYTES) begin
			len = $urandom_range(1, 24);
			build_datagram(len, 1'b0, $urandom_range(0, 99) < 15);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < wire_bytes.size(); i++) begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			gap = steady ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			push <= 1'b1;
			offered <= wire_bytes[i];
			do @(posedge clk); while (full);
		end
		@(negedge clk);
		push <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
